### hdl/pfb_pkg.sv
// shared types and constants for the page framebuffer rectangle drawer
// no dependencies
`default_nettype none

package pfb_pkg;

  localparam int DEF_DISPLAY_WIDTH  = 160;
  localparam int DEF_DISPLAY_HEIGHT = 48;
  localparam int ROWS_PER_PAGE      = 8;

  // fixed coordinate widths, set by the field widths and parameter ranges
  localparam int COL_W  = 8;
  localparam int ROW_W  = 6;
  localparam int PAGE_W = 3;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_RECT  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_RMW,
    OP_ZERO
  } mem_op_t;

  typedef struct packed {
    mem_op_t    op;
    logic [7:0] set_mask;
    logic [7:0] clr_mask;
  } mem_req_t;

  typedef struct packed {
    logic out_load;
    logic out_zero;
  } seq_out_t;

endpackage

`default_nettype wire

### hdl/page_framebuffer_rect_draw.sv
// monochrome page framebuffer with clear, pixel, rectangle and read commands
// top level; depends on pfb_pkg, pfb_store and pfb_seq
//
// usage:
//   input channel (in_valid / in_stall) takes one command item per handshake:
//   clear, set pixel, draw rectangle or read byte. only read byte produces a
//   result item, on the output channel (out_valid / out_stall), in read_data.
//   coordinates off the display are clipped pixel by pixel; reads outside the
//   store return zero.
// operation:
//   clear walks the whole store, one byte per cycle.
//   set pixel reads the byte, then writes it back; in_stall stays high for both.
//   rectangle walks the clipped columns of each covered page, one byte per
//   cycle, through the single read-modify-write port of the store.
//   read passes S_READ and S_READ_OUT to the output register (an out-of-range
//   read skips S_READ); the result then sits in the output register until taken.
// reset: a clearing pass over all pages * width bytes (960 at the default size)
//   runs first; in_stall stays high until it ends.
// stall: while out_stall holds a result, the block still takes clear, pixel
//   and rectangle items; a second read waits until the output register frees.
`default_nettype none

module page_framebuffer_rect_draw import pfb_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command,
  input  wire logic signed [8:0] x,
  input  wire logic signed [8:0] y,
  input  wire logic [7:0]        rect_width,
  input  wire logic [7:0]        rect_height,
  input  wire logic              fill,
  input  wire logic              pixel_on,
  input  wire logic [2:0]        read_page,
  input  wire logic [7:0]        read_column,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             read_data
);

  localparam int PAGE_COUNT = (DISPLAY_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int DEPTH      = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);

  mem_req_t          req;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        rd_data;
  logic              wb_busy;
  logic              out_free;
  seq_out_t          ctl;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  pfb_seq #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .x           (x),
    .y           (y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .fill        (fill),
    .pixel_on    (pixel_on),
    .read_page   (read_page),
    .read_column (read_column),
    .wb_busy     (wb_busy),
    .out_free    (out_free),
    .req         (req),
    .addr        (addr),
    .ctl         (ctl)
  );

  pfb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .addr    (addr),
    .rd_data (rd_data),
    .wb_busy (wb_busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      read_data <= ctl.out_zero ? 8'd0 : rd_data;
    end
  end

endmodule

`default_nettype wire

### hdl/pfb_store.sv
// frame store memory with read-modify-write back stage
// depends on pfb_pkg
`default_nettype none

module pfb_store import pfb_pkg::*; #(
  parameter int DEPTH = DEF_DISPLAY_WIDTH *
                        ((DEF_DISPLAY_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mem_req_t                 req,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  output logic [7:0]                    rd_data,
  output logic                          wb_busy
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [ADDR_W-1:0] wb_addr;
  logic [7:0]        wb_set;
  logic [7:0]        wb_clr;

  always_ff @(posedge clk) begin
    if (wb_busy) begin
      mem[wb_addr] <= (rd_data & ~wb_clr) | wb_set;
    end else if (req.op == OP_ZERO) begin
      mem[addr] <= 8'd0;
    end
    if (req.op == OP_READ || req.op == OP_RMW) begin
      rd_data <= mem[addr];
    end
    wb_addr <= addr;
    wb_set  <= req.set_mask;
    wb_clr  <= req.clr_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_busy <= 1'b0;
    end else begin
      wb_busy <= (req.op == OP_RMW);
    end
  end

endmodule

`default_nettype wire

### hdl/pfb_seq.sv
// command sequencer: clipping, clear sweep, pixel and rectangle walks, reads
// depends on pfb_pkg
`default_nettype none

module pfb_seq import pfb_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              command,
  input  wire logic signed [8:0]       x,
  input  wire logic signed [8:0]       y,
  input  wire logic [7:0]              rect_width,
  input  wire logic [7:0]              rect_height,
  input  wire logic                    fill,
  input  wire logic                    pixel_on,
  input  wire logic [2:0]              read_page,
  input  wire logic [7:0]              read_column,
  input  wire logic                    wb_busy,
  input  wire logic                    out_free,
  output mem_req_t                     req,
  output logic [$clog2(DISPLAY_WIDTH *
    ((DISPLAY_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE))-1:0] addr,
  output seq_out_t                     ctl
);

  localparam int PAGE_COUNT = (DISPLAY_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int DEPTH      = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam logic signed [9:0] W_S       = 10'(DISPLAY_WIDTH);
  localparam logic signed [9:0] H_S       = 10'(DISPLAY_HEIGHT);
  localparam logic [COL_W-1:0]  W_LAST    = COL_W'(DISPLAY_WIDTH - 1);
  localparam logic [ROW_W-1:0]  H_LAST    = ROW_W'(DISPLAY_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] W_ADDR    = ADDR_W'(DISPLAY_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [8:0]        W_9       = 9'(DISPLAY_WIDTH);
  localparam logic [3:0]        PAGES_4   = 4'(PAGE_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_PIXEL,
    S_RECT,
    S_READ,
    S_READ_OUT
  } state_t;

  state_t state;

  logic                acc;
  logic signed [9:0]   x_ext, x_end, y_ext, y_end;
  logic                x_empty, y_empty, pix_ok, rd_ok;
  logic [COL_W-1:0]    cl_in, ch_in;
  logic [ROW_W-1:0]    rl_in, rh_in;
  logic                top_on_in, bot_on_in;
  logic [ADDR_W-1:0]   pix_addr, rd_addr, rect_base;
  logic [7:0]          pix_bit;

  // registered work description
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   base;
  logic [COL_W-1:0]    col, cl, ch;
  logic [PAGE_W-1:0]   page;
  logic [ROW_W-1:0]    rl, rh, top_row, bot_row;
  logic                top_on, bot_on, fill_r, rd_zero;
  logic signed [9:0]   x0_r, xe_r;
  logic [7:0]          pix_set, pix_clr;

  logic [2:0]          lo, hi;
  logic [7:0]          span, edge_bits, rect_mask;
  logic signed [9:0]   col_s;
  logic                side;

  assign acc = in_valid && !in_stall;

  // clipping of the incoming item
  assign x_ext = {x[8], x};
  assign y_ext = {y[8], y};
  assign x_end = x_ext + $signed({2'b00, rect_width}) - 10'sd1;
  assign y_end = y_ext + $signed({2'b00, rect_height}) - 10'sd1;

  assign x_empty = (rect_width == 8'd0) || (x_ext >= W_S) || (x_end < 10'sd0);
  assign y_empty = (rect_height == 8'd0) || (y_ext >= H_S) || (y_end < 10'sd0);
  assign cl_in   = x[8] ? '0 : x[COL_W-1:0];
  assign ch_in   = (x_end >= W_S) ? W_LAST : x_end[COL_W-1:0];
  assign rl_in   = y[8] ? '0 : y[ROW_W-1:0];
  assign rh_in   = (y_end >= H_S) ? H_LAST : y_end[ROW_W-1:0];
  assign top_on_in = !y[8] && (y_ext < H_S);
  assign bot_on_in = !y_end[9] && (y_end < H_S);

  assign pix_ok   = !x[8] && (x_ext < W_S) && !y[8] && (y_ext < H_S);
  assign pix_addr = ADDR_W'(y[5:3]) * W_ADDR + ADDR_W'(x[COL_W-1:0]);
  assign pix_bit  = 8'd1 << y[2:0];
  assign rect_base = ADDR_W'(rl_in[5:3]) * W_ADDR;

  assign rd_ok   = ({1'b0, read_page} < PAGES_4) && ({1'b0, read_column} < W_9);
  assign rd_addr = ADDR_W'(read_page) * W_ADDR + ADDR_W'(read_column);

  // byte mask for the current column of the rectangle walk
  always_comb begin
    lo = (page == rl[5:3]) ? rl[2:0] : 3'd0;
    hi = (page == rh[5:3]) ? rh[2:0] : 3'd7;
    span = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    edge_bits = 8'd0;
    if (top_on && top_row[5:3] == page) begin
      edge_bits = edge_bits | (8'd1 << top_row[2:0]);
    end
    if (bot_on && bot_row[5:3] == page) begin
      edge_bits = edge_bits | (8'd1 << bot_row[2:0]);
    end
    col_s = {2'b00, col};
    side  = fill_r || (col_s == x0_r) || (col_s == xe_r);
    rect_mask = side ? span : edge_bits;
  end

  always_comb begin
    req.op       = OP_NONE;
    req.set_mask = 8'd0;
    req.clr_mask = 8'd0;
    addr         = addr_r;
    unique case (state)
      S_CLEAR: begin
        req.op = OP_ZERO;
      end
      S_PIXEL: begin
        req.op       = OP_RMW;
        req.set_mask = pix_set;
        req.clr_mask = pix_clr;
      end
      S_RECT: begin
        req.op       = OP_RMW;
        req.set_mask = rect_mask;
        addr         = base + ADDR_W'(col);
      end
      S_READ: begin
        req.op = OP_READ;
      end
      default: begin
        req.op = OP_NONE;
      end
    endcase
  end

  assign in_stall     = (state != S_IDLE) || wb_busy;
  assign ctl.out_load = (state == S_READ_OUT) && out_free;
  assign ctl.out_zero = rd_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      addr_r <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (command)
              CMD_CLEAR: begin
                addr_r <= '0;
                state  <= S_CLEAR;
              end
              CMD_PIXEL: begin
                addr_r  <= pix_addr;
                pix_set <= pixel_on ? pix_bit : 8'd0;
                pix_clr <= pixel_on ? 8'd0 : pix_bit;
                if (pix_ok) begin
                  state <= S_PIXEL;
                end
              end
              CMD_RECT: begin
                col     <= cl_in;
                cl      <= cl_in;
                ch      <= ch_in;
                rl      <= rl_in;
                rh      <= rh_in;
                page    <= rl_in[5:3];
                base    <= rect_base;
                top_on  <= top_on_in;
                bot_on  <= bot_on_in;
                top_row <= y[ROW_W-1:0];
                bot_row <= y_end[ROW_W-1:0];
                x0_r    <= x_ext;
                xe_r    <= x_end;
                fill_r  <= fill;
                if (!x_empty && !y_empty) begin
                  state <= S_RECT;
                end
              end
              CMD_READ: begin
                addr_r  <= rd_addr;
                rd_zero <= !rd_ok;
                state   <= rd_ok ? S_READ : S_READ_OUT;
              end
            endcase
          end
        end
        S_CLEAR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_PIXEL: begin
          state <= S_IDLE;
        end
        S_RECT: begin
          if (col == ch) begin
            col  <= cl;
            page <= page + 1'b1;
            base <= base + W_ADDR;
            if (page == rh[5:3]) begin
              state <= S_IDLE;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_READ: begin
          state <= S_READ_OUT;
        end
        S_READ_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/page_framebuffer_rect_draw_tb.sv
// self-checking testbench for the page framebuffer rectangle drawer
// depends on pfb_pkg and page_framebuffer_rect_draw; a directed table, then random items
`timescale 1ns / 1ps

module page_framebuffer_rect_draw_tb;
  import pfb_pkg::*;

  // display geometry, kept at the block's defaults
  localparam int DISP_W      = DEF_DISPLAY_WIDTH;
  localparam int DISP_H      = DEF_DISPLAY_HEIGHT;
  localparam int PAGES       = (DISP_H + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int STORE_BYTES = DISP_W * PAGES;

  localparam int N_RAND  = 1850;
  localparam int MAX_GAP = 60;
  // worst case per item: a whole-store walk plus the longest gap on both sides,
  // plus the clearing pass after reset, all taken four times over
  localparam int LIMIT_CYCLES =
    4 * (2 * STORE_BYTES + (N_RAND + 40) * (STORE_BYTES + 2 + 2 * MAX_GAP));

  // one command item as it crosses the input channel
  typedef struct packed {
    logic [1:0]        command;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic              fill;
    logic              pixel_on;
    logic [2:0]        read_page;
    logic [7:0]        read_column;
  } fb_item_t;

  // directed row: item plus an optional typed-in read result
  typedef struct packed {
    fb_item_t   item;
    logic       typed;
    logic [7:0] typed_byte;
  } dir_row_t;

  logic              clk;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [1:0]        command     = CMD_CLEAR;
  logic signed [8:0] x           = '0;
  logic signed [8:0] y           = '0;
  logic [7:0]        rect_width  = '0;
  logic [7:0]        rect_height = '0;
  logic              fill        = 1'b0;
  logic              pixel_on    = 1'b0;
  logic [2:0]        read_page   = '0;
  logic [7:0]        read_column = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [7:0]        read_data;

  // predictor state and the bytes that reads still owe us
  logic [7:0] model_store [STORE_BYTES];
  logic [7:0] exp_read_bytes [$];
  logic [7:0] exp_head;
  int         err_cnt = 0;

  // recent drawing position, used to aim reads at touched bytes
  int last_x = 0;
  int last_y = 0;

  // out_stall pattern state
  int stall_left = 0;
  int stall_pick;

  dir_row_t dir_tbl [$];

  page_framebuffer_rect_draw #(
    .DISPLAY_WIDTH (DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .x          (x),
    .y          (y),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .fill       (fill),
    .pixel_on   (pixel_on),
    .read_page  (read_page),
    .read_column(read_column),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  // set or clear one pixel, silently skipping anything off the display
  task automatic plot_pixel(input int col, input int row, input bit on);
    int idx;
    logic [7:0] mask;
    if (col < 0 || col >= DISP_W || row < 0 || row >= DISP_H) return;
    idx  = col + (row / ROWS_PER_PAGE) * DISP_W;
    mask = 8'(1 << (row % ROWS_PER_PAGE));
    if (on) model_store[idx] = model_store[idx] | mask;
    else    model_store[idx] = model_store[idx] & ~mask;
  endtask

  // advance the store model by one item; a read hands back its byte
  task automatic frame_model_apply(input fb_item_t it, output bit has_byte,
                                   output logic [7:0] rd_byte);
    int x0, y0, x1, y1, ilo, ihi, jlo, jhi;
    has_byte = 1'b0;
    rd_byte  = '0;
    x0 = $signed(it.x);
    y0 = $signed(it.y);
    case (it.command)
      CMD_CLEAR: begin
        foreach (model_store[k]) model_store[k] = '0;
      end
      CMD_PIXEL: begin
        plot_pixel(x0, y0, it.pixel_on);
      end
      CMD_RECT: begin
        // always sets; zero size draws nothing since the loops are empty
        x1  = x0 + int'(it.rect_width) - 1;
        y1  = y0 + int'(it.rect_height) - 1;
        // walk only the visible part, edges still judged on the full box
        ilo = (x0 < 0) ? 0 : x0;
        ihi = (x1 > DISP_W - 1) ? DISP_W - 1 : x1;
        jlo = (y0 < 0) ? 0 : y0;
        jhi = (y1 > DISP_H - 1) ? DISP_H - 1 : y1;
        for (int i = ilo; i <= ihi; i++) begin
          for (int j = jlo; j <= jhi; j++) begin
            if (it.fill || i == x0 || i == x1 || j == y0 || j == y1)
              plot_pixel(i, j, 1'b1);
          end
        end
      end
      default: begin
        // read byte: out of range gives zero
        has_byte = 1'b1;
        if (int'(it.read_page) < PAGES && int'(it.read_column) < DISP_W)
          rd_byte = model_store[int'(it.read_page) * DISP_W + int'(it.read_column)];
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic fb_item_t mk_item(input logic [1:0] cmd, input int xv, input int yv,
                                       input int wv, input int hv, input bit fl,
                                       input bit on, input int pg, input int col);
    fb_item_t it;
    it.command     = cmd;
    it.x           = 9'(xv);
    it.y           = 9'(yv);
    it.rect_width  = 8'(wv);
    it.rect_height = 8'(hv);
    it.fill        = fl;
    it.pixel_on    = on;
    it.read_page   = 3'(pg);
    it.read_column = 8'(col);
    return it;
  endfunction

  function automatic dir_row_t mk_row(input fb_item_t it, input bit typed,
                                      input logic [7:0] b);
    dir_row_t r;
    r.item       = it;
    r.typed      = typed;
    r.typed_byte = b;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, MAX_GAP);
  endfunction

  // random item: every field starts fully random, then the named ones get shaped
  function automatic fb_item_t rand_item();
    fb_item_t   it;
    logic [63:0] raw;
    int r;
    raw = {$urandom(), $urandom()};
    it  = raw[$bits(fb_item_t)-1:0];
    r   = $urandom_range(0, 99);
    if (r < 2) begin
      it.command = CMD_CLEAR;
    end else if (r < 36) begin
      it.command = CMD_PIXEL;
      // mostly on the display, some anywhere in the signed range
      if ($urandom_range(0, 99) < 85) it.x = 9'($urandom_range(0, DISP_W - 1));
      if ($urandom_range(0, 99) < 85) it.y = 9'($urandom_range(0, DISP_H - 1));
      if ($signed(it.x) >= 0 && $signed(it.x) < DISP_W &&
          $signed(it.y) >= 0 && $signed(it.y) < DISP_H) begin
        last_x = $signed(it.x);
        last_y = $signed(it.y);
      end
    end else if (r < 64) begin
      it.command = CMD_RECT;
      if ($urandom_range(0, 99) < 80) it.x = 9'(int'($urandom_range(0, DISP_W + 7)) - 8);
      if ($urandom_range(0, 99) < 80) it.y = 9'(int'($urandom_range(0, DISP_H + 7)) - 8);
      // small boxes keep the walk short; a few big or empty ones
      r = $urandom_range(0, 99);
      if (r < 3) begin
        it.rect_width  = (r == 0) ? 8'd0 : 8'($urandom_range(0, 16));
        it.rect_height = (r == 0) ? 8'($urandom_range(0, 16)) : 8'd0;
      end else if (r < 93) begin
        it.rect_width  = 8'($urandom_range(1, 16));
        it.rect_height = 8'($urandom_range(1, 16));
      end else begin
        it.rect_width  = 8'($urandom_range(1, 255));
        it.rect_height = 8'($urandom_range(1, 255));
      end
      if ($signed(it.x) >= 0 && $signed(it.x) < DISP_W &&
          $signed(it.y) >= 0 && $signed(it.y) < DISP_H) begin
        last_x = $signed(it.x);
        last_y = $signed(it.y);
      end
    end else begin
      it.command = CMD_READ;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // aim at something recently drawn
        it.read_column = 8'(last_x + int'($urandom_range(0, 2)) - 1);
        it.read_page   = 3'(last_y / ROWS_PER_PAGE);
      end else if (r < 90) begin
        it.read_column = 8'($urandom_range(0, DISP_W - 1));
        it.read_page   = 3'($urandom_range(0, PAGES - 1));
      end
    end
    return it;
  endfunction

  // drive one item and hold it until the block takes it, then predict
  task automatic send_item(input fb_item_t it, input int gap, input bit typed,
                           input logic [7:0] typed_byte);
    bit         has_byte;
    logic [7:0] pred_byte;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= it.command;
    x           <= it.x;
    y           <= it.y;
    rect_width  <= it.rect_width;
    rect_height <= it.rect_height;
    fill        <= it.fill;
    pixel_on    <= it.pixel_on;
    read_page   <= it.read_page;
    read_column <= it.read_column;
    do @(posedge clk); while (in_stall !== 1'b0);
    frame_model_apply(it, has_byte, pred_byte);
    if (has_byte) exp_read_bytes.push_back(typed ? typed_byte : pred_byte);
  endtask

  // ---------------------------------------------------------------- output side

  // receiver stall: random phases, with occasional long stall-free stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 35) begin
        out_stall  <= 1'b1;
        stall_left <= gap_len();
      end else if (stall_pick < 45) begin
        out_stall  <= 1'b0;
        stall_left <= 200;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= gap_len();
      end
    end
  end

  // result check against the oldest owed byte
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (exp_read_bytes.size() == 0) begin
        $error("unexpected result item: read_data actual %02h", read_data);
        err_cnt++;
      end else begin
        exp_head = exp_read_bytes.pop_front();
        if (read_data !== exp_head) begin
          $error("read_data mismatch: expected %02h, actual %02h", exp_head, read_data);
          err_cnt++;
        end
      end
    end
  end

  // hang guard
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    bit burst;
    burst = 1'b0;

    // directed table; typed bytes only where the answer is obvious
    // empty store after reset, plus every out-of-range read flavor
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, PAGES - 1, DISP_W - 1),
                             1, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, PAGES, 0), 1, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 7, 255), 1, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, DISP_W), 1, 8'h00));
    // corner pixels
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h01));
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, DISP_W - 1, DISP_H - 1, 0, 0, 0, 1, 0, 0),
                             0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, PAGES - 1, DISP_W - 1),
                             1, 8'h80));
    // off-display pixels are dropped
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, -1, 0, 0, 0, 0, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, DISP_W, 0, 0, 0, 0, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, 0, DISP_H, 0, 0, 0, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, -256, 255, 0, 0, 0, 1, 0, 0), 0, 8'h00));
    // pixel clear
    dir_tbl.push_back(mk_row(mk_item(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00));
    // outline with pixel_on low, which the rectangle ignores
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, 10, 2, 5, 6, 0, 0, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 12), 0, 8'h00));
    // empty rectangles
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, 30, 0, 0, 10, 1, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, 30, 0, 10, 0, 1, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 30), 1, 8'h00));
    // thin outline comes out solid
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, 20, 20, 2, 3, 0, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 2, 20), 0, 8'h00));
    // outline whose every edge is just off the display
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, -1, -1, DISP_W + 2, DISP_H + 2, 0, 1, 0, 0),
                             0, 8'h00));
    // largest size, clipped on the left, top and bottom
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, -100, -5, 255, 255, 1, 0, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 3, 100), 1, 8'hFF));
    // clear, then an outline of the whole display
    dir_tbl.push_back(mk_row(mk_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 3, 100), 1, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_RECT, 0, 0, DISP_W, DISP_H, 0, 1, 0, 0), 0, 8'h00));
    dir_tbl.push_back(mk_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 2, 0), 0, 8'h00));

    // model starts cleared, like the block
    foreach (model_store[k]) model_store[k] = '0;

    // release reset; the block's clearing pass follows behind in_stall
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i])
      send_item(dir_tbl[i].item, gap_len(), dir_tbl[i].typed, dir_tbl[i].typed_byte);

    // random part; every so often a run of back-to-back items
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      send_item(rand_item(), burst ? 0 : gap_len(), 1'b0, 8'h00);
    end
    in_valid <= 1'b0;

    // drain owed reads, then leave room for a trailing whole-store walk
    while (exp_read_bytes.size() != 0) @(posedge clk);
    repeat (STORE_BYTES + 8) @(posedge clk);
    if (exp_read_bytes.size() != 0) begin
      $error("read_data items still owed: %0d", exp_read_bytes.size());
      err_cnt++;
    end

    if (err_cnt == 0) $display("Simulation PASSED");
    else              $display("Simulation FAILED");
    $finish;
  end

endmodule
